### sv/srbs_pkg.sv
// ----------------------------------------------------------------------------
// srbs_pkg
// Shared constants, codes and types for the step rate synthesizer with
// backlash take-up.
// ----------------------------------------------------------------------------
package srbs_pkg;

  localparam int MAX_STEP_SIZE_DEF = 256;

  // 16e6 ticks per second times 256 for the Q24.8 rate
  localparam logic [31:0] PERIOD_NUM   = 32'd4096000000;
  // 130 s in 1/16 us
  localparam logic [30:0] PERIOD_LIMIT = 31'd2080000000;
  localparam logic [30:0] MAX_RATE_RST = 31'd256000;

  localparam logic [1:0] FUNC_SET_RATE = 2'd0;
  localparam logic [1:0] FUNC_TICK     = 2'd1;
  localparam logic [1:0] FUNC_BASELINE = 2'd2;

  localparam logic [1:0] REG_MAX_RATE        = 2'd0;
  localparam logic [1:0] REG_BACKLASH_RATE   = 2'd1;
  localparam logic [1:0] REG_BACKLASH_AMOUNT = 2'd2;

  typedef struct packed {
    logic [30:0] max_rate;
    logic [30:0] backlash_rate;
    logic [15:0] backlash_amount;
  } cfg_t;

  typedef struct packed {
    logic [31:0] motor_position;
    logic [31:0] target_position;
    logic [17:0] backlash_position;
    logic        in_backlash;
    logic [30:0] tick_period;
    logic [9:0]  step_increment;
    logic [31:0] feed_forward_rate;
    logic        period_changed;
  } result_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_CMP,
    ST_SEARCH,
    ST_DIVIDE,
    ST_CHECK,
    ST_APPLY,
    ST_TICK_TGT,
    ST_TICK_CMP,
    ST_TICK_MOVE,
    ST_BASE,
    ST_DONE
  } state_t;

endpackage

### sv/srbs_cfg.sv
// ----------------------------------------------------------------------------
// srbs_cfg
// APB register file: max rate, backlash rate and backlash amount.
// ----------------------------------------------------------------------------
module srbs_cfg (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output srbs_pkg::cfg_t    cfg
);
  import srbs_pkg::*;

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_rate        <= MAX_RATE_RST;
      cfg.backlash_rate   <= '0;
      cfg.backlash_amount <= '0;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        REG_MAX_RATE:        cfg.max_rate        <= pwdata[30:0];
        REG_BACKLASH_RATE:   cfg.backlash_rate   <= pwdata[30:0];
        REG_BACKLASH_AMOUNT: cfg.backlash_amount <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_MAX_RATE:        prdata = {1'b0, cfg.max_rate};
      REG_BACKLASH_RATE:   prdata = {1'b0, cfg.backlash_rate};
      REG_BACKLASH_AMOUNT: prdata = {16'd0, cfg.backlash_amount};
      default:             prdata = '0;
    endcase
  end

endmodule

### sv/srbs_div.sv
// ----------------------------------------------------------------------------
// srbs_div
// Bit-serial restoring divider: one quotient bit per cycle.
// ----------------------------------------------------------------------------
module srbs_div #(
  parameter int NUM_W = 40,
  parameter int DEN_W = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo,
  output logic [DEN_W-1:0] rem
);
  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] sh;
  logic [DEN_W-1:0] part;
  logic [DEN_W-1:0] den_q;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             fits;

  // next dividend bit shifts into the partial remainder
  assign trial = {part, sh[NUM_W-1]};
  assign diff  = trial - {1'b0, den_q};
  assign fits  = trial >= {1'b0, den_q};
  assign quo   = sh;
  assign rem   = part;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NUM_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sh    <= num;
      part  <= '0;
      den_q <= den;
    end else if (busy) begin
      part <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      sh   <= {sh[NUM_W-2:0], fits};
    end
  end

  a_start_loads: assert property (@(posedge clk) disable iff (rst)
    start |=> (busy && cnt == CNT_W'(NUM_W)))
    else $error("divider did not load on start");

  a_rem_below_den: assert property (@(posedge clk) disable iff (rst)
    done |-> (!busy && (den_q == '0 || part < den_q)))
    else $error("remainder not reduced at done");

  a_fall_done: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> done)
    else $error("divider stopped without done");

endmodule

### sv/srbs_ctrl.sv
// ----------------------------------------------------------------------------
// srbs_ctrl
// Sequencer and axis state: rate setup with step size search and period
// division, tick handling with backlash take-up, baseline reset.
// ----------------------------------------------------------------------------
module srbs_ctrl #(
  parameter int MAX_STEP_SIZE = srbs_pkg::MAX_STEP_SIZE_DEF,
  parameter int NUM_W         = 40
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_func,
  input  logic [31:0]       in_rate,
  input  logic              in_enabled,
  input  logic              in_sync,
  input  srbs_pkg::cfg_t    cfg,
  output logic              res_valid,
  input  logic              out_free,
  output srbs_pkg::result_t res,
  output logic              div_start,
  output logic [NUM_W-1:0]  div_num,
  output logic [31:0]       div_den,
  input  logic              div_done,
  input  logic [NUM_W-1:0]  div_quo,
  input  logic [31:0]       div_rem
);
  import srbs_pkg::*;

  localparam int K_MAX = $clog2(MAX_STEP_SIZE + 1) - 1;
  localparam int KW    = (K_MAX > 0) ? $clog2(K_MAX + 1) : 1;

  state_t state, state_next;

  // axis state
  logic [31:0] motor_pos;
  logic [31:0] target_pos;
  logic [17:0] backlash;
  logic        backlash_flag;
  logic [KW-1:0] step_k;
  logic [9:0]  signed_step;
  logic [31:0] current_rate;
  logic [30:0] period;
  logic [31:0] feed_fwd;
  logic        changed;

  // per-item working registers
  logic [31:0]      rate_q;
  logic             enabled_q;
  logic             sync_q;
  logic [31:0]      f_reg;
  logic             dir_neg;
  logic             dir_nz;
  logic [KW-1:0]    k_cnt;
  logic [NUM_W-1:0] cmp_reg;
  logic             tgt_lt;
  logic             mot_lt;

  logic             search_more;
  logic [31:0]      mag;
  logic             q_ok;
  logic             round_up;
  logic [30:0]      period_new;
  logic [8:0]       step_mag;
  logic [9:0]       step_ext;
  logic [9:0]       abs10;
  logic [8:0]       abs_step;
  logic [17:0]      amount18;
  logic [17:0]      b_dec;
  logic [17:0]      b_inc;

  assign search_more = (k_cnt < KW'(K_MAX)) && (NUM_W'(f_reg) >= cmp_reg);
  assign mag         = rate_q[31] ? (~rate_q + 32'd1) : rate_q;
  assign q_ok        = (div_quo < NUM_W'(PERIOD_LIMIT)) ||
                       ((div_quo == NUM_W'(PERIOD_LIMIT)) && (div_rem == '0));
  // round half up: remainder at least half the divisor
  assign round_up    = {div_rem, 1'b0} >= {1'b0, f_reg};
  assign period_new  = div_quo[30:0] + 31'(round_up);
  assign step_mag    = 9'd1 << step_k;
  assign step_ext    = {1'b0, step_mag};
  assign abs10       = signed_step[9] ? (~signed_step + 10'd1) : signed_step;
  assign abs_step    = abs10[8:0];
  assign amount18    = {2'b00, cfg.backlash_amount};
  assign b_dec       = backlash - {9'd0, abs_step};
  assign b_inc       = backlash + {9'd0, abs_step};

  assign div_num = NUM_W'(PERIOD_NUM) << k_cnt;
  assign div_den = f_reg;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          unique case (in_func)
            FUNC_SET_RATE: state_next = ST_PREP;
            FUNC_TICK:     state_next = ST_TICK_TGT;
            FUNC_BASELINE: state_next = ST_BASE;
            default:       state_next = ST_DONE;
          endcase
        end
      end
      ST_PREP:      state_next = enabled_q ? ST_CMP : ST_DONE;
      ST_CMP:       state_next = (f_reg == current_rate) ? ST_APPLY : ST_SEARCH;
      ST_SEARCH: begin
        if (!search_more) state_next = (f_reg == '0) ? ST_APPLY : ST_DIVIDE;
      end
      ST_DIVIDE: begin
        if (div_done) state_next = ST_CHECK;
      end
      ST_CHECK:     state_next = ST_APPLY;
      ST_APPLY:     state_next = ST_DONE;
      ST_TICK_TGT:  state_next = ST_TICK_CMP;
      ST_TICK_CMP:  state_next = ST_TICK_MOVE;
      ST_TICK_MOVE: state_next = ST_DONE;
      ST_BASE:      state_next = ST_DONE;
      ST_DONE: begin
        if (out_free) state_next = ST_IDLE;
      end
      default:      state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (state == ST_IDLE);
    res_valid = (state == ST_DONE);
    div_start = (state == ST_SEARCH) && !search_more && (f_reg != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      motor_pos     <= '0;
      target_pos    <= '0;
      backlash      <= '0;
      backlash_flag <= 1'b0;
      step_k        <= '0;
      signed_step   <= '0;
      current_rate  <= '0;
      period        <= '0;
      feed_fwd      <= '0;
      changed       <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_valid) changed <= 1'b0;
        end
        ST_PREP: begin
          if (!enabled_q) begin
            feed_fwd <= '0;
            if (period != '0 || signed_step != '0) begin
              current_rate <= '0;
              period       <= '0;
              signed_step  <= '0;
              changed      <= 1'b1;
            end
          end
        end
        ST_SEARCH: begin
          if (!search_more) begin
            step_k  <= k_cnt;
            changed <= 1'b1;
            if (f_reg == '0) begin
              period       <= '0;
              current_rate <= '0;
            end
          end
        end
        ST_CHECK: begin
          if (q_ok) begin
            period       <= period_new;
            current_rate <= f_reg;
          end else begin
            period       <= '0;
            current_rate <= '0;
          end
        end
        ST_APPLY: begin
          if (!dir_nz)      signed_step <= '0;
          else if (dir_neg) signed_step <= ~step_ext + 10'd1;
          else              signed_step <= step_ext;
          if (!dir_nz || period == '0 || f_reg == '0) feed_fwd <= '0;
          else if (!dir_neg) feed_fwd <= f_reg[31] ? 32'h7FFF_FFFF : f_reg;
          else               feed_fwd <= ~f_reg + 32'd1;
        end
        ST_TICK_TGT: begin
          if (sync_q && !backlash_flag)
            target_pos <= target_pos + {{22{signed_step[9]}}, signed_step};
        end
        ST_TICK_MOVE: begin
          if (tgt_lt) begin
            if ($signed(backlash) > 18'sd0) begin
              backlash      <= b_dec;
              backlash_flag <= $signed(b_dec) > 18'sd0;
            end else begin
              motor_pos     <= motor_pos - {23'd0, abs_step};
              backlash_flag <= 1'b0;
            end
          end else if (mot_lt || backlash_flag) begin
            if ($signed(backlash) < $signed(amount18)) begin
              backlash      <= b_inc;
              backlash_flag <= $signed(b_inc) < $signed(amount18);
            end else begin
              motor_pos     <= motor_pos + {23'd0, abs_step};
              backlash_flag <= 1'b0;
            end
          end
        end
        ST_BASE: begin
          signed_step   <= '0;
          backlash_flag <= 1'b0;
          backlash      <= '0;
          current_rate  <= '0;
          period        <= '0;
          step_k        <= '0;
          feed_fwd      <= '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          rate_q    <= in_rate;
          enabled_q <= in_enabled;
          sync_q    <= in_sync;
        end
      end
      ST_PREP: begin
        f_reg   <= backlash_flag ? {1'b0, cfg.backlash_rate} : mag;
        dir_neg <= rate_q[31];
        dir_nz  <= rate_q != '0;
      end
      ST_CMP: begin
        k_cnt   <= '0;
        cmp_reg <= NUM_W'(cfg.max_rate);
      end
      ST_SEARCH: begin
        if (search_more) begin
          k_cnt   <= k_cnt + KW'(1);
          cmp_reg <= cmp_reg << 1;
        end else if (f_reg == '0) begin
          dir_nz <= 1'b0;
        end
      end
      ST_CHECK: begin
        if (!q_ok) begin
          f_reg  <= '0;
          dir_nz <= 1'b0;
        end
      end
      ST_TICK_CMP: begin
        tgt_lt <= $signed(target_pos) < $signed(motor_pos);
        mot_lt <= $signed(motor_pos) < $signed(target_pos);
      end
      default: ;
    endcase
  end

  always_comb begin
    res.motor_position    = motor_pos;
    res.target_position   = target_pos;
    res.backlash_position = backlash;
    res.in_backlash       = backlash_flag;
    res.tick_period       = period;
    res.step_increment    = signed_step;
    res.feed_forward_rate = feed_fwd;
    res.period_changed    = changed;
  end

  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && !out_free) |=> (state == ST_DONE && $stable(res)))
    else $error("result changed while output stalled");

  a_step_size: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && signed_step != '0) |-> (abs10 == step_ext))
    else $error("per-tick step disagrees with step size");

  a_ff_sign: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && feed_fwd != '0) |->
      (signed_step != '0 && feed_fwd[31] == signed_step[9]))
    else $error("feed-forward direction disagrees with step");

endmodule

### sv/step_rate_backlash_synthesizer_core.sv
// ----------------------------------------------------------------------------
// step_rate_backlash_synthesizer_core
// Step rate synthesizer for one axis with backlash take-up.
//
//   channel  dir  signals                      content
//   s_       in   tvalid tready tdata tuser    func, rate and flags
//   m_       out  tvalid tready tdata          axis state after the item
//   apb      in   psel penable pwrite paddr..  max_rate, backlash_rate/amount
//
// A rate change runs the step size search and, for a nonzero rate, the
// bit-serial period divider; a same-rate set rate, a tick, a disabled set
// rate, a baseline and an unused code skip both.
// Reset is synchronous and clears the axis state; there is no clearing pass.
// A result waits in the output register while the next item is processed;
// the sequencer holds its next result until that register is free.
// ----------------------------------------------------------------------------
module step_rate_backlash_synthesizer_core #(
  parameter int MAX_STEP_SIZE = srbs_pkg::MAX_STEP_SIZE_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [39:0]  s_tdata,   // rate[31:0], motor_enabled[32], sync[33], zero pad
  input  logic [1:0]   s_tuser,   // func[1:0]
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [159:0] m_tdata,   // motor_position[31:0], target_position[63:32],
                                  // backlash_position[81:64], in_backlash[82],
                                  // tick_period[113:83], step_increment[123:114],
                                  // feed_forward_rate[155:124], period_changed[156],
                                  // zero pad
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import srbs_pkg::*;

  localparam int K_MAX = $clog2(MAX_STEP_SIZE + 1) - 1;
  localparam int NUM_W = 32 + K_MAX;

  cfg_t             cfg;
  result_t          res;
  logic             res_valid;
  logic             out_free;
  logic             div_start;
  logic [NUM_W-1:0] div_num;
  logic [31:0]      div_den;
  logic             div_done;
  logic [NUM_W-1:0] div_quo;
  logic [31:0]      div_rem;

  srbs_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  srbs_div #(
    .NUM_W (NUM_W),
    .DEN_W (32)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo),
    .rem   (div_rem)
  );

  srbs_ctrl #(
    .MAX_STEP_SIZE (MAX_STEP_SIZE),
    .NUM_W         (NUM_W)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_func    (s_tuser),
    .in_rate    (s_tdata[31:0]),
    .in_enabled (s_tdata[32]),
    .in_sync    (s_tdata[33]),
    .cfg        (cfg),
    .res_valid  (res_valid),
    .out_free   (out_free),
    .res        (res),
    .div_start  (div_start),
    .div_num    (div_num),
    .div_den    (div_den),
    .div_done   (div_done),
    .div_quo    (div_quo),
    .div_rem    (div_rem)
  );

  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && out_free) begin
      m_tdata <= {3'b000, res.period_changed, res.feed_forward_rate,
                  res.step_increment, res.tick_period, res.in_backlash,
                  res.backlash_position, res.target_position, res.motor_position};
    end
  end

endmodule

### tb/tb_step_rate_backlash_synthesizer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_step_rate_backlash_synthesizer_core
// Drives set rate, tick, baseline and unused items into the axis core under
// several register settings and checks every reported axis state, field by
// field, against an in-bench model of the rate, step and backlash logic.
// ----------------------------------------------------------------------------
module tb_step_rate_backlash_synthesizer_core;
  import srbs_pkg::*;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int         IDLE_PCT    = 23;
  localparam int         SETTLE_CYC  = 80;
  localparam int         CYCLE_LIMIT = 600000;

  typedef struct {
    logic [1:0]  op;
    logic [31:0] rate;
    bit          enabled;
    bit          sync;
  } axis_item_t;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [39:0]  s_tdata;   // rate[31:0], motor_enabled[32], sync[33], zero pad
  logic [1:0]   s_tuser;   // func[1:0]
  logic         m_tvalid;
  logic         m_tready;
  logic [159:0] m_tdata;   // motor_position, target_position, backlash_position,
                           // in_backlash, tick_period, step_increment,
                           // feed_forward_rate, period_changed, zero pad
  logic         psel;
  logic         penable;
  logic         pwrite;
  logic [3:0]   paddr;
  logic [31:0]  pwdata;
  logic [31:0]  prdata;
  logic         pready;

  step_rate_backlash_synthesizer_core i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // register shadow
  logic [30:0] cfg_max_rate;
  logic [30:0] cfg_bl_rate;
  logic [15:0] cfg_bl_amount;

  // axis model state
  logic signed [31:0] mot_pos;
  logic signed [31:0] tgt_pos;
  int                 bl_pos;
  bit                 bl_active;
  int                 step_sz;
  int                 step_inc;
  logic [31:0]        cur_mag;
  longint unsigned    period;
  longint             ff_rate;

  axis_item_t feed_q[$];
  result_t    axis_state_q[$];
  bit         in_taken;
  bit         steady_run;
  int         errors;
  int         cycles;
  logic [31:0] last_rate;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // rate change: step size, period and direction; returns 1 on timer reload
  function automatic bit retune(logic [31:0] raw, bit enabled);
    logic [31:0]     mag;
    logic [31:0]     f;
    int              dir;
    longint unsigned s;
    longint unsigned fm;
    bit              changed;
    changed = 1'b0;
    if (!enabled) begin
      ff_rate = 0;
      if (period == 0 && step_inc == 0) return 1'b0;
      cur_mag  = '0;
      period   = 0;
      step_inc = 0;
      return 1'b1;
    end
    dir = 0;
    mag = raw;
    if (raw[31]) begin
      mag = -raw;
      dir = -1;
    end else if (raw != 0) begin
      dir = 1;
    end
    f = bl_active ? {1'b0, cfg_bl_rate} : mag;
    if (f != cur_mag) begin
      fm = 64'(f);
      s  = 1;
      while (s * 2 <= 64'(MAX_STEP_SIZE_DEF) && fm >= 64'(cfg_max_rate) * s)
        s = s * 2;
      step_sz = int'(s);
      if (f != 0 && 64'(PERIOD_NUM) * s <= 64'(PERIOD_LIMIT) * fm) begin
        period = (2 * 64'(PERIOD_NUM) * s + fm) / (2 * fm);
      end else begin
        period = 0;
        f      = '0;
        dir    = 0;
      end
      cur_mag = f;
      changed = 1'b1;
    end
    step_inc = dir * step_sz;
    if (dir == 0 || period == 0 || f == 0) begin
      ff_rate = 0;
    end else if (dir > 0) begin
      ff_rate = (f > 32'h7FFF_FFFF) ? 64'sd2147483647 : longint'({32'b0, f});
    end else begin
      ff_rate = -longint'({32'b0, f});
    end
    return changed;
  endfunction

  function automatic void step_tick(bit sync);
    int abs_step;
    int amount;
    abs_step = (step_inc < 0) ? -step_inc : step_inc;
    amount   = int'({16'b0, cfg_bl_amount});
    if (sync && !bl_active) tgt_pos = tgt_pos + 32'(step_inc);
    if (tgt_pos < mot_pos) begin
      if (bl_pos > 0) begin
        bl_pos    = bl_pos - abs_step;
        bl_active = bl_pos > 0;
      end else begin
        mot_pos   = mot_pos - 32'(abs_step);
        bl_active = 1'b0;
      end
    end else if (mot_pos < tgt_pos || bl_active) begin
      if (bl_pos < amount) begin
        bl_pos    = bl_pos + abs_step;
        bl_active = bl_pos < amount;
      end else begin
        mot_pos   = mot_pos + 32'(abs_step);
        bl_active = 1'b0;
      end
    end
  endfunction

  function automatic result_t advance_axis(axis_item_t it);
    result_t r;
    bit      changed;
    changed = 1'b0;
    case (it.op)
      FUNC_SET_RATE: changed = retune(it.rate, it.enabled);
      FUNC_TICK:     step_tick(it.sync);
      FUNC_BASELINE: begin
        step_inc  = 0;
        bl_active = 1'b0;
        bl_pos    = 0;
        cur_mag   = '0;
        period    = 0;
        step_sz   = 1;
        ff_rate   = 0;
      end
      default: ;
    endcase
    r.motor_position    = mot_pos;
    r.target_position   = tgt_pos;
    r.backlash_position = 18'(bl_pos);
    r.in_backlash       = bl_active;
    r.tick_period       = period[30:0];
    r.step_increment    = 10'(step_inc);
    r.feed_forward_rate = ff_rate[31:0];
    r.period_changed    = changed;
    return r;
  endfunction

  function automatic logic [31:0] reg_value(logic [1:0] idx);
    case (idx)
      REG_MAX_RATE:        return {1'b0, cfg_max_rate};
      REG_BACKLASH_RATE:   return {1'b0, cfg_bl_rate};
      REG_BACKLASH_AMOUNT: return {16'b0, cfg_bl_amount};
      default:             return '0;
    endcase
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %h, got %h", name, want, got);
      errors++;
    end
  endtask

  // result check, input prediction and register shadow, all at the rising edge
  always @(posedge clk) begin
    result_t want;
    axis_item_t it;
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      in_taken <= s_tvalid && s_tready;
      if (!rst) begin
        if (m_tvalid && m_tready) begin
          if (axis_state_q.size() == 0) begin
            $error("unexpected item on m_ side: %h", m_tdata);
            errors++;
          end else begin
            want = axis_state_q.pop_front();
            check_field("motor_position", want.motor_position, m_tdata[31:0]);
            check_field("target_position", want.target_position, m_tdata[63:32]);
            check_field("backlash_position", 32'(want.backlash_position),
                        32'(m_tdata[81:64]));
            check_field("in_backlash", 32'(want.in_backlash), 32'(m_tdata[82]));
            check_field("tick_period", 32'(want.tick_period), 32'(m_tdata[113:83]));
            check_field("step_increment", 32'(want.step_increment),
                        32'(m_tdata[123:114]));
            check_field("feed_forward_rate", want.feed_forward_rate,
                        m_tdata[155:124]);
            check_field("period_changed", 32'(want.period_changed),
                        32'(m_tdata[156]));
          end
        end
        if (s_tvalid && s_tready) begin
          it.op      = s_tuser;
          it.rate    = s_tdata[31:0];
          it.enabled = s_tdata[32];
          it.sync    = s_tdata[33];
          axis_state_q.push_back(advance_axis(it));
        end
        if (psel && penable && pready) begin
          if (pwrite) begin
            case (paddr[3:2])
              REG_MAX_RATE:        cfg_max_rate  = pwdata[30:0];
              REG_BACKLASH_RATE:   cfg_bl_rate   = pwdata[30:0];
              REG_BACKLASH_AMOUNT: cfg_bl_amount = pwdata[15:0];
              default: ;
            endcase
          end else begin
            check_field("prdata", reg_value(paddr[3:2]), prdata);
          end
        end
      end
    end
  end

  // input driver and output stall, both at the falling edge
  always @(negedge clk) begin
    axis_item_t it;
    m_tready <= steady_run || ($urandom_range(0, 99) >= IDLE_PCT);
    if (!(s_tvalid && !in_taken)) begin
      if (feed_q.size() != 0 && (steady_run || $urandom_range(0, 99) >= IDLE_PCT)) begin
        it = feed_q.pop_front();
        s_tvalid <= 1'b1;
        s_tuser  <= it.op;
        s_tdata  <= {6'b0, it.sync, it.enabled, it.rate};
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  task automatic push_item(logic [1:0] op, logic [31:0] rate, bit enabled, bit sync);
    axis_item_t it;
    it.op      = op;
    it.rate    = rate;
    it.enabled = enabled;
    it.sync    = sync;
    feed_q.push_back(it);
  endtask

  task automatic apb_access(logic [1:0] idx, bit wr, logic [31:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic program_axis(logic [30:0] mr, logic [30:0] br, logic [15:0] ba);
    apb_access(REG_MAX_RATE, 1'b1, {1'b0, mr});
    apb_access(REG_BACKLASH_RATE, 1'b1, {1'b0, br});
    apb_access(REG_BACKLASH_AMOUNT, 1'b1, {16'b0, ba});
    apb_access(REG_MAX_RATE, 1'b0, '0);
    apb_access(REG_BACKLASH_RATE, 1'b0, '0);
    apb_access(REG_BACKLASH_AMOUNT, 1'b0, '0);
  endtask

  // checked at the rising edge, where the driver never changes the input side
  task automatic wait_drained();
    while (feed_q.size() != 0 || s_tvalid || axis_state_q.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYC) @(negedge clk);
  endtask

  function automatic logic [31:0] pick_rate();
    logic [31:0] mag;
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return '0;
      2: begin
        case ($urandom_range(0, 2))
          0:       return 32'h8000_0000;
          1:       return 32'h7FFF_FFFF;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      3, 4: mag = ({1'b0, cfg_max_rate} << $urandom_range(0, 9)) +
                  32'($urandom_range(0, 2)) - 32'd1;
      default: mag = $urandom >> $urandom_range(1, 31);
    endcase
    return $urandom_range(0, 1) ? -mag : mag;
  endfunction

  // well-formed motion segments with random content, plus some noise
  task automatic fill_random(int n);
    int added;
    int k;
    int m;
    added = 0;
    while (added < n) begin
      k = $urandom_range(0, 99);
      if (k < 62) begin
        last_rate = (k < 50) ? pick_rate() : -last_rate;
        push_item(FUNC_SET_RATE, last_rate, 1'b1, 1'($urandom_range(0, 1)));
        m = $urandom_range(1, 12);
        for (int j = 0; j < m; j++)
          push_item(FUNC_TICK, $urandom, 1'($urandom_range(0, 1)),
                    $urandom_range(0, 9) != 0);
        added += m + 1;
      end else begin
        if (k < 70)
          push_item(FUNC_SET_RATE, $urandom, 1'b0, 1'($urandom_range(0, 1)));
        else if (k < 76)
          push_item(FUNC_SET_RATE, last_rate, 1'b1, 1'($urandom_range(0, 1)));
        else if (k < 80)
          push_item(FUNC_BASELINE, $urandom, 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)));
        else if (k < 84)
          push_item(FUNC_UNUSED, $urandom, 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)));
        else
          push_item(FUNC_TICK, $urandom, 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)));
        added++;
      end
    end
  endtask

  initial begin
    rst        = 1'b1;
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    s_tuser    = FUNC_SET_RATE;
    m_tready   = 1'b0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    in_taken   = 1'b0;
    steady_run = 1'b0;
    errors     = 0;
    cycles     = 0;
    last_rate  = 32'd25600;
    cfg_max_rate  = MAX_RATE_RST;
    cfg_bl_rate   = '0;
    cfg_bl_amount = '0;
    mot_pos   = '0;
    tgt_pos   = '0;
    bl_pos    = 0;
    bl_active = 1'b0;
    step_sz   = 1;
    step_inc  = 0;
    cur_mag   = '0;
    period    = 0;
    ff_rate   = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed part
    program_axis(MAX_RATE_RST, 31'd200000, 16'd12);
    push_item(FUNC_TICK, '0, 1'b1, 1'b1);
    push_item(FUNC_SET_RATE, 32'd25600, 1'b1, 1'b0);
    repeat (3) push_item(FUNC_TICK, '0, 1'b1, 1'b1);
    push_item(FUNC_SET_RATE, 32'd25600, 1'b1, 1'b0);
    push_item(FUNC_SET_RATE, -32'd25600, 1'b1, 1'b0);
    repeat (3) push_item(FUNC_TICK, '0, 1'b1, 1'b1);
    push_item(FUNC_SET_RATE, 32'h7FFF_FFFF, 1'b1, 1'b1);
    push_item(FUNC_SET_RATE, 32'h8000_0000, 1'b1, 1'b1);
    // rate too slow for the timer: motion stops
    push_item(FUNC_SET_RATE, 32'd1, 1'b1, 1'b0);
    push_item(FUNC_SET_RATE, -32'd600000, 1'b1, 1'b0);
    push_item(FUNC_TICK, 32'hFFFF_FFFF, 1'b0, 1'b1);
    push_item(FUNC_TICK, '0, 1'b1, 1'b0);
    push_item(FUNC_SET_RATE, 32'd512000, 1'b0, 1'b0);
    push_item(FUNC_SET_RATE, 32'd512000, 1'b0, 1'b0);
    push_item(FUNC_UNUSED, 32'hFFFF_FFFF, 1'b1, 1'b1);
    push_item(FUNC_BASELINE, '0, 1'b1, 1'b0);
    push_item(FUNC_SET_RATE, '0, 1'b1, 1'b0);
    push_item(FUNC_TICK, '0, 1'b1, 1'b1);
    fill_random(100);
    wait_drained();

    program_axis(31'd1, 31'h7FFF_FFFF, 16'hFFFF);
    fill_random(110);
    wait_drained();

    // no idling on either side for this setting
    steady_run = 1'b1;
    program_axis(31'h7FFF_FFFF, '0, '0);
    fill_random(110);
    wait_drained();
    steady_run = 1'b0;

    // zero max_rate always picks the largest step size
    program_axis('0, 31'd5000, 16'd3);
    fill_random(110);
    wait_drained();

    program_axis(31'($urandom_range(1000, 2000000)), 31'($urandom),
                 16'($urandom_range(0, 40)));
    fill_random(130);
    wait_drained();

    program_axis(MAX_RATE_RST, 31'd128000, 16'd7);
    fill_random(130);
    wait_drained();

    if (errors == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
